>>> sv/pdbc_pkg.sv
// ----------------------------------------------------------------------------
// pdbc_pkg
// Shared widths, register indexes and result-kind codes for the PID
// controller with dead band and full-drive band.
// ----------------------------------------------------------------------------
package pdbc_pkg;

    localparam int IN_W     = 16;   // setpoint / measured
    localparam int ERR_W    = 17;   // signed error
    localparam int GAIN_W   = 16;
    localparam int BAND_W   = 16;
    localparam int LIM_W    = 15;
    localparam int DRIVE_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // first difference, second difference
    localparam int D1_W = ERR_W + 1;
    localparam int D2_W = ERR_W + 2;

    // products of an unsigned gain (one extra sign bit) with a signed operand
    localparam int KP_PROD_W = GAIN_W + 1 + D1_W;
    localparam int KI_PROD_W = GAIN_W + 1 + ERR_W;
    localparam int KD_PROD_W = GAIN_W + 1 + D2_W;
    localparam int SUM_W     = KD_PROD_W + 2;

    localparam logic [LIM_W-1:0] OUTPUT_LIMIT_RST = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP_GAIN      = 3'd0,
        REG_KI_GAIN      = 3'd1,
        REG_KD_GAIN      = 3'd2,
        REG_LIMIT_BAND   = 3'd3,
        REG_DEAD_BAND    = 3'd4,
        REG_OUTPUT_LIMIT = 3'd5
    } reg_idx_t;

    // how the drive of one item is formed
    typedef enum logic [2:0] {
        KIND_HOLD = 3'd0,
        KIND_POS  = 3'd1,
        KIND_NEG  = 3'd2,
        KIND_ZERO = 3'd3,
        KIND_PID  = 3'd4
    } kind_t;

endpackage

>>> sv/pid_deadband_bangbang_controller.sv
// ----------------------------------------------------------------------------
// pid_deadband_bangbang_controller
// Incremental PID with dead band and full-drive band, three-stage pipeline.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | contents
//  ---------+-------------------------------------------+--------------------
//  s_axis   | s_axis_tvalid/tready/tdata[31:0]          | setpoint, measured
//  m_axis   | m_axis_tvalid/tready/tdata[15:0]          | drive (signed)
//  cfg      | cfg_valid/ready, cfg_index[2:0], cfg_data | register write
//
//  One beat per cycle unless stalled: input register, product register
//  (17x18, 17x17, 17x19 multipliers), output register (sum, clamp, hold).
//  Error history advances when a PID beat leaves the input register; the
//  held drive advances when a beat enters the output register.
//  Reset: gains and bands 0, output limit 32767, history and held drive 0.
//  m_axis_tready low backs up stage by stage; s_axis_tready falls only when
//  all three stages are full. cfg_ready is always high.
// ----------------------------------------------------------------------------
module pid_deadband_bangbang_controller
    import pdbc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [2*IN_W-1:0]    s_axis_tdata,   // [15:0] setpoint, [31:16] measured

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [DRIVE_W-1:0]   m_axis_tdata,   // [15:0] drive

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    // configuration
    logic [GAIN_W-1:0] kp_gain_reg, ki_gain_reg, kd_gain_reg;
    logic [BAND_W-1:0] limit_band_reg, dead_band_reg;
    logic [LIM_W-1:0]  output_limit_reg;

    // state
    logic signed [ERR_W-1:0]   e1_reg, e2_reg;
    logic signed [DRIVE_W-1:0] held_drive_reg;

    // pipeline
    logic                      s1_vld_reg;
    logic [IN_W-1:0]           s1_sp_reg, s1_mv_reg;
    logic                      s2_vld_reg;
    kind_t                     s2_kind_reg;
    logic signed [KP_PROD_W-1:0] s2_kp_prod_reg;
    logic signed [KI_PROD_W-1:0] s2_ki_prod_reg;
    logic signed [KD_PROD_W-1:0] s2_kd_prod_reg;
    logic                      out_vld_reg;
    logic signed [DRIVE_W-1:0] out_drive_reg;

    logic out_ready, s2_ready, s1_ready;
    logic s1_load, s2_load, out_load, hist_we;

    logic signed [ERR_W-1:0]     err;
    logic signed [ERR_W:0]       err_x, lb_s, db_s;
    logic signed [D1_W-1:0]      d1;
    logic signed [D2_W-1:0]      d2;
    kind_t                       kind_next;
    logic signed [KP_PROD_W-1:0] kp_prod_next;
    logic signed [KI_PROD_W-1:0] ki_prod_next;
    logic signed [KD_PROD_W-1:0] kd_prod_next;

    logic signed [SUM_W-1:0]     pid_sum, lim_wide;
    logic signed [DRIVE_W-1:0]   lim_s, pid_drive, drive_next;

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    assign out_ready     = !out_vld_reg || m_axis_tready;
    assign s2_ready      = !s2_vld_reg || out_ready;
    assign s1_ready      = !s1_vld_reg || s2_ready;
    assign s1_load       = s_axis_tvalid && s1_ready;
    assign s2_load       = s1_vld_reg && s2_ready;
    assign out_load      = s2_vld_reg && out_ready;

    assign s_axis_tready = s1_ready;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_drive_reg;
    assign cfg_ready     = 1'b1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_gain_reg      <= '0;
            ki_gain_reg      <= '0;
            kd_gain_reg      <= '0;
            limit_band_reg   <= '0;
            dead_band_reg    <= '0;
            output_limit_reg <= OUTPUT_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_KP_GAIN:      kp_gain_reg      <= cfg_data;
                REG_KI_GAIN:      ki_gain_reg      <= cfg_data;
                REG_KD_GAIN:      kd_gain_reg      <= cfg_data;
                REG_LIMIT_BAND:   limit_band_reg   <= cfg_data;
                REG_DEAD_BAND:    dead_band_reg    <= cfg_data;
                REG_OUTPUT_LIMIT: output_limit_reg <= cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage 1: input register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (s1_ready)
            s1_vld_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_sp_reg <= s_axis_tdata[IN_W-1:0];
            s1_mv_reg <= s_axis_tdata[2*IN_W-1:IN_W];
        end
    end

    // ------------------------------------------------------------------
    // classify, differences, products
    // ------------------------------------------------------------------
    always_comb
    begin
        err   = $signed({1'b0, s1_sp_reg}) - $signed({1'b0, s1_mv_reg});
        err_x = {err[ERR_W-1], err};
        lb_s  = $signed({2'b00, limit_band_reg});
        db_s  = $signed({2'b00, dead_band_reg});

        // limit band takes priority over dead band
        if (err == '0)
            kind_next = KIND_HOLD;
        else if (err_x > lb_s)
            kind_next = KIND_POS;
        else if (err_x < -lb_s)
            kind_next = KIND_NEG;
        else if (err_x < db_s && err_x > -db_s)
            kind_next = KIND_ZERO;
        else
            kind_next = KIND_PID;

        d1 = err_x - {e1_reg[ERR_W-1], e1_reg};
        d2 = {{2{err[ERR_W-1]}}, err} - {e1_reg[ERR_W-1], e1_reg, 1'b0}
           + {{2{e2_reg[ERR_W-1]}}, e2_reg};

        kp_prod_next = $signed({1'b0, kp_gain_reg}) * d1;
        ki_prod_next = $signed({1'b0, ki_gain_reg}) * err;
        kd_prod_next = $signed({1'b0, kd_gain_reg}) * d2;
    end

    assign hist_we = s2_load && (kind_next == KIND_PID);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_reg <= '0;
            e2_reg <= '0;
        end
        else if (hist_we)
        begin
            e1_reg <= err;
            e2_reg <= e1_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: product register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (s2_ready)
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_kind_reg    <= kind_next;
            s2_kp_prod_reg <= kp_prod_next;
            s2_ki_prod_reg <= ki_prod_next;
            s2_kd_prod_reg <= kd_prod_next;
        end
    end

    // ------------------------------------------------------------------
    // sum, clamp, select
    // ------------------------------------------------------------------
    always_comb
    begin
        pid_sum  = SUM_W'(s2_kp_prod_reg) + SUM_W'(s2_ki_prod_reg)
                 + SUM_W'(s2_kd_prod_reg);
        lim_wide = $signed({{(SUM_W-LIM_W){1'b0}}, output_limit_reg});
        lim_s    = $signed({1'b0, output_limit_reg});

        if (pid_sum > lim_wide)
            pid_drive = lim_s;
        else if (pid_sum < -lim_wide)
            pid_drive = -lim_s;
        else
            pid_drive = pid_sum[DRIVE_W-1:0];

        unique case (s2_kind_reg)
            KIND_HOLD: drive_next = held_drive_reg;
            KIND_POS:  drive_next = lim_s;
            KIND_NEG:  drive_next = -lim_s;
            KIND_ZERO: drive_next = '0;
            KIND_PID:  drive_next = pid_drive;
            default:   drive_next = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // stage 3: output register and held drive
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg    <= 1'b0;
            held_drive_reg <= '0;
        end
        else
        begin
            if (out_ready)
                out_vld_reg <= s2_vld_reg;
            if (out_load)
                held_drive_reg <= drive_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_drive_reg <= drive_next;
    end

`ifndef NO_ASSERTIONS
    // input side stalls only with every stage full and the output blocked
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (s1_vld_reg && s2_vld_reg && out_vld_reg && !m_axis_tready))
        else $error("input stalled with a free pipeline stage");

    // history shifts as a pair
    a_hist_shift: assert property (@(posedge clk) disable iff (!rst_n)
        hist_we |=> (e2_reg == $past(e1_reg)))
        else $error("error history did not shift");

    a_hist_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !hist_we |=> ($stable(e1_reg) && $stable(e2_reg)))
        else $error("error history changed outside a PID beat");

    // held drive follows the last beat loaded to the output
    a_held_track: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (held_drive_reg == out_drive_reg))
        else $error("held drive out of step with output");

    a_dead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && s2_kind_reg == KIND_ZERO) |=> (out_drive_reg == '0))
        else $error("dead band beat gave nonzero drive");
`endif

endmodule
